[rtl/sllm_pkg.sv]
// Shared widths and command codes of the static linked list merge core.
`timescale 1ns / 1ps
`default_nettype none
package sllm_pkg;

	localparam int SLOTS_PER_LIST_DEF = 16;
	localparam int MAX_RESULTS        = 32;

	localparam int KIND_W  = 2;
	localparam int SLOT_W  = 4;
	localparam int VALUE_W = 64;
	localparam int LINK_W  = 5;
	localparam int MSLOT_W = 5;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD_A = 2'd0,
		KIND_LOAD_B = 2'd1,
		KIND_START  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

endpackage
`default_nettype wire

[rtl/static_linked_list_merge_core.sv]
// Top level of the merge core for two sorted index-linked lists.
//
// Usage: drive kind and the payload fields with start high; a word is taken
// at a rising edge where start is high and busy is low. Kind 0 and 1 write
// one slot of list A or list B into the slot store (list B at offset
// SLOTS_PER_LIST) and the core stays in idle. Kind 2 starts a
// merge from head_a and head_b; busy stays high while the walk runs.
// Each merged word appears on merged_value, merged_slot and last with
// strobe high for exactly one cycle; the receiver cannot stall it.
// After the start is taken, FETCH_A and FETCH_B read both heads (2 reads) and
// CAP_B captures head B; EMIT then raises strobe for the first word. Each word
// needs one read of the next slot of its list from the single-port slot store
// (state LOAD), and the compare waits for that registered read before the next
// word. The walk stops after min(2*SLOTS_PER_LIST, 32) words.
// Two empty lists give no word. Kind 3 and loads past the list are dropped.
// Reset clears the sequencer and the cursors; the slot store is not cleared
// and a slot that was never loaded reads back undefined.
`timescale 1ns / 1ps
`default_nettype none
module static_linked_list_merge_core #(
	parameter int SLOTS_PER_LIST = sllm_pkg::SLOTS_PER_LIST_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic        [sllm_pkg::KIND_W-1:0]   kind,
	input  wire logic        [sllm_pkg::SLOT_W-1:0]   slot_index,
	input  wire logic signed [sllm_pkg::VALUE_W-1:0]  value,
	input  wire logic signed [sllm_pkg::LINK_W-1:0]   link,
	input  wire logic signed [sllm_pkg::LINK_W-1:0]   head_a,
	input  wire logic signed [sllm_pkg::LINK_W-1:0]   head_b,
	output logic                                      strobe,
	output logic signed      [sllm_pkg::VALUE_W-1:0]  merged_value,
	output logic             [sllm_pkg::MSLOT_W-1:0]  merged_slot,
	output logic                                      last
);

	import sllm_pkg::*;

	localparam int DEPTH  = 2 * SLOTS_PER_LIST;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LIMIT  = (DEPTH > MAX_RESULTS) ? MAX_RESULTS : DEPTH;
	localparam int CNT_W  = $clog2(LIMIT + 1);
	localparam int CMP_W  = 7;
	localparam int WORD_W = VALUE_W + LINK_W;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_FETCH_A = 6'b000010,
		ST_FETCH_B = 6'b000100,
		ST_CAP_B   = 6'b001000,
		ST_EMIT    = 6'b010000,
		ST_LOAD    = 6'b100000
	} state_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} cursor_t;

	// Turn a raw link or head into a store index; negative or past the list is null.
	function automatic cursor_t decode(input logic [LINK_W-1:0] raw, input logic list_b);
		cursor_t      c;
		logic [CMP_W-1:0] sum;
		sum   = CMP_W'(raw[LINK_W-2:0]) + (list_b ? CMP_W'(SLOTS_PER_LIST) : CMP_W'(0));
		c.vld = !raw[LINK_W-1] && (CMP_W'(raw[LINK_W-2:0]) < CMP_W'(SLOTS_PER_LIST));
		c.idx = sum[IDX_W-1:0];
		return c;
	endfunction

	state_t state_q;
	cursor_t cur_a_q, cur_b_q;
	logic [CNT_W-1:0] count_q;
	logic side_b_q;

	logic [VALUE_W-1:0] a_val_q, b_val_q;
	logic [LINK_W-1:0]  a_link_q, b_link_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_addr;
	logic [WORD_W-1:0]  ram_wdata;
	logic [WORD_W-1:0]  ram_rdata;
	logic [VALUE_W-1:0] rd_val;
	logic [LINK_W-1:0]  rd_link;

	logic               accept;
	logic               load_ok;
	logic [CMP_W-1:0]   wr_sum;
	logic               take_a;
	cursor_t            nxt;
	logic               emit_last;
	logic               any_vld;

	assign accept  = start && !busy;
	assign busy    = (state_q != ST_IDLE);
	assign rd_val  = ram_rdata[VALUE_W-1:0];
	assign rd_link = ram_rdata[WORD_W-1:VALUE_W];

	assign load_ok = ((kind == KIND_LOAD_A) || (kind == KIND_LOAD_B)) &&
		(CMP_W'(slot_index) < CMP_W'(SLOTS_PER_LIST));
	assign wr_sum  = CMP_W'(slot_index) +
		((kind == KIND_LOAD_B) ? CMP_W'(SLOTS_PER_LIST) : CMP_W'(0));

	assign any_vld = cur_a_q.vld || cur_b_q.vld;
	assign take_a  = cur_a_q.vld &&
		(!cur_b_q.vld || ($signed(a_val_q) <= $signed(b_val_q)));

	always_comb begin
		if (take_a) begin
			nxt       = decode(a_link_q, 1'b0);
			emit_last = !nxt.vld && !cur_b_q.vld;
		end else begin
			nxt       = decode(b_link_q, 1'b1);
			emit_last = !nxt.vld && !cur_a_q.vld;
		end
		if (count_q == CNT_W'(LIMIT - 1)) begin
			emit_last = 1'b1;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = {link, value};
		case (state_q)
			ST_IDLE: begin
				ram_we   = accept && load_ok;
				ram_addr = wr_sum[IDX_W-1:0];
			end
			ST_FETCH_A: ram_addr = cur_a_q.idx;
			ST_FETCH_B: ram_addr = cur_b_q.idx;
			ST_EMIT:    ram_addr = nxt.idx;
			default:    ram_addr = '0;
		endcase
	end

	sllm_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH),
		.AW   (IDX_W)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cur_a_q  <= '0;
			cur_b_q  <= '0;
			count_q  <= '0;
			side_b_q <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (kind == KIND_START)) begin
						cur_a_q <= decode(head_a, 1'b0);
						cur_b_q <= decode(head_b, 1'b1);
						count_q <= '0;
						state_q <= ST_FETCH_A;
					end
				end
				ST_FETCH_A: state_q <= ST_FETCH_B;
				ST_FETCH_B: state_q <= ST_CAP_B;
				ST_CAP_B:   state_q <= ST_EMIT;
				ST_EMIT: begin
					if (!any_vld) begin
						state_q <= ST_IDLE;
					end else begin
						strobe   <= 1'b1;
						count_q  <= count_q + CNT_W'(1);
						side_b_q <= !take_a;
						if (take_a) begin
							cur_a_q <= nxt;
						end else begin
							cur_b_q <= nxt;
						end
						state_q <= emit_last ? ST_IDLE : ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_EMIT;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Slot contents at the cursor of each list and the result word.
	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH_B || (state_q == ST_LOAD && !side_b_q)) begin
			a_val_q  <= rd_val;
			a_link_q <= rd_link;
		end
		if (state_q == ST_CAP_B || (state_q == ST_LOAD && side_b_q)) begin
			b_val_q  <= rd_val;
			b_link_q <= rd_link;
		end
		if (state_q == ST_EMIT) begin
			merged_value <= take_a ? a_val_q : b_val_q;
			merged_slot  <= MSLOT_W'(CMP_W'(take_a ? cur_a_q.idx : cur_b_q.idx));
			last         <= emit_last;
		end
	end

endmodule
`default_nettype wire

[rtl/sllm_ram.sv]
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sllm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire
